[rtl/tlsd_pkg.sv]
// Shared types and constants for the toroidal Life block.
// It depends on nothing. The lanes, merge and top-level files use it.
package tlsd_pkg;

   localparam int GRID_WIDTH_DEF  = 64;
   localparam int GRID_HEIGHT_DEF = 32;

   localparam logic [31:0] FNV_BASIS     = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME     = 32'd16777619;
   localparam logic [7:0]  LIMIT_DEFAULT = 8'd30;
   localparam logic [7:0]  REPEAT_MAX    = 8'd255;
   localparam logic [11:0] POP_MAX       = 12'd4095;

   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_REPEAT_LIMIT = 3'd0;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_READ  = 2'd1,
      ACT_STEP  = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FETCH,
      ST_LOAD,
      ST_CALC,
      ST_WRITE,
      ST_HASH,
      ST_EVAL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic init;
      logic load;
   } merge_ctrl_type;

   typedef struct packed {
      logic busy;
   } merge_stat_type;

endpackage

[rtl/toroidal_life_step_with_stall_detect.sv]
// Top level of the toroidal Life block: grid memory, step sequencer,
// history checks and ports. It depends on tlsd_pkg, tlsd_lanes, tlsd_merge.
//
//   Channel   Direction  Transfer when              Contents
//   req_*     in         req_tvalid & req_tready    tuser action, tdata column/cells
//   rsp_*     out        rsp_tvalid & rsp_tready    one result per request
//   csr_*     in         psel & penable & pwrite    repeat_limit at address 0
//
// Requests are taken only in the idle state, so each request finishes before the next
// one is taken. During a step the merge stage folds one cell per cycle into the hash
// multiplier, and each column needs one memory read.
// Reset is synchronous; the grid reads dead through per-column valid bits.
// A new request is taken while a finished result waits on rsp.
module toroidal_life_step_with_stall_detect #(
   parameter int GRID_WIDTH  = tlsd_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = tlsd_pkg::GRID_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [1:0]                      req_tuser,   // action
   input  logic [39:0]                     req_tdata,   // column, cells_in
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cells_out, population, grid_hash, stimulus_needed, generation
   output logic [111:0]                    rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tlsd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   localparam int CW = $clog2(GRID_WIDTH);
   localparam int FW = $clog2(GRID_WIDTH + 3);
   localparam int PW = $clog2(GRID_WIDTH * GRID_HEIGHT + 1);
   localparam int H  = GRID_HEIGHT;

   tlsd_pkg::state_type state_ff, state_in;

   tlsd_pkg::action_type action_ff;
   logic [5:0]           column_ff;
   logic [31:0]          cells_ff;

   logic [H-1:0]          mem [2][GRID_WIDTH];
   logic [GRID_WIDTH-1:0] valid_ff [2];
   logic                  sel_ff;
   logic [H-1:0]          rd_data_ff;
   logic                  rd_valid_ff;

   logic [FW-1:0] fetch_ff;
   logic [FW-1:0] fetch_m1;
   logic [CW-1:0] x_ff;
   logic [H-1:0]  prev_ff, cur_ff, nxt_ff;
   logic [H-1:0]  rd_word;
   logic [H-1:0]  new_col;

   logic [31:0] last_hash_ff, older_hash_ff, generation_ff;
   logic [7:0]  repeat_count_ff, repeat_limit_ff, repeat_inc;
   logic        pending_ff;

   logic [31:0]   merge_hash;
   logic [PW-1:0] merge_pop;
   tlsd_pkg::merge_ctrl_type merge_ctrl;
   tlsd_pkg::merge_stat_type merge_stat;

   logic          rd_en, wr_en, wr_bank, lanes_en, out_load, out_free;
   logic [CW-1:0] rd_addr, wr_addr;
   logic [H-1:0]  wr_data;
   logic [8:0]    column_ext;
   logic          column_ok;
   logic [63:0]   cells_wide;
   logic [63:0]   rd_wide;
   logic          req_xfer, csr_write;

   logic         rsp_valid_ff;
   logic [31:0]  out_cells_ff, out_hash_ff, out_gen_ff;
   logic [11:0]  out_pop_ff;
   logic         out_stim_ff;
   logic [11:0]  pop_sat;

   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign column_ext = 9'(column_ff);
   assign column_ok  = column_ext < 9'(GRID_WIDTH);
   assign cells_wide = 64'(cells_ff);
   assign rd_wide    = 64'(rd_word);
   assign rd_word    = rd_valid_ff ? rd_data_ff : '0;
   assign fetch_m1   = fetch_ff - FW'(1);
   assign pop_sat    = (16'(merge_pop) > 16'(tlsd_pkg::POP_MAX)) ? tlsd_pkg::POP_MAX
                                                                 : 12'(merge_pop);
   assign repeat_inc = (repeat_count_ff < tlsd_pkg::REPEAT_MAX) ? repeat_count_ff + 8'd1
                                                                 : repeat_count_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tlsd_pkg::ST_IDLE: begin
            if (req_xfer) state_in = tlsd_pkg::ST_EXEC;
         end
         tlsd_pkg::ST_EXEC: begin
            if (action_ff == tlsd_pkg::ACT_STEP) state_in = tlsd_pkg::ST_FETCH;
            else                                 state_in = tlsd_pkg::ST_FINISH;
         end
         tlsd_pkg::ST_FETCH: state_in = tlsd_pkg::ST_LOAD;
         tlsd_pkg::ST_LOAD: begin
            if (fetch_ff >= FW'(3)) state_in = tlsd_pkg::ST_CALC;
            else                    state_in = tlsd_pkg::ST_FETCH;
         end
         tlsd_pkg::ST_CALC:  state_in = tlsd_pkg::ST_WRITE;
         tlsd_pkg::ST_WRITE: state_in = tlsd_pkg::ST_HASH;
         tlsd_pkg::ST_HASH: begin
            if (!merge_stat.busy) begin
               if (x_ff == CW'(GRID_WIDTH - 1)) state_in = tlsd_pkg::ST_EVAL;
               else                             state_in = tlsd_pkg::ST_FETCH;
            end
         end
         tlsd_pkg::ST_EVAL: state_in = tlsd_pkg::ST_FINISH;
         tlsd_pkg::ST_FINISH: begin
            if (out_free) state_in = tlsd_pkg::ST_IDLE;
         end
         default: state_in = tlsd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready      = 1'b0;
      rd_en           = 1'b0;
      rd_addr         = '0;
      wr_en           = 1'b0;
      wr_bank         = sel_ff;
      wr_addr         = column_ext[CW-1:0];
      wr_data         = cells_wide[H-1:0];
      lanes_en        = 1'b0;
      merge_ctrl      = '0;
      out_load        = 1'b0;
      case (state_ff)
         tlsd_pkg::ST_IDLE: req_tready = 1'b1;
         tlsd_pkg::ST_EXEC: begin
            case (action_ff)
               tlsd_pkg::ACT_WRITE: wr_en = column_ok;
               tlsd_pkg::ACT_READ: begin
                  rd_en   = 1'b1;
                  rd_addr = column_ext[CW-1:0];
               end
               tlsd_pkg::ACT_STEP: merge_ctrl.init = 1'b1;
               default: ;
            endcase
         end
         tlsd_pkg::ST_FETCH: begin
            rd_en = 1'b1;
            if (fetch_ff == '0)                    rd_addr = CW'(GRID_WIDTH - 1);
            else if (fetch_ff <= FW'(GRID_WIDTH))  rd_addr = fetch_m1[CW-1:0];
            else                                   rd_addr = '0;
         end
         tlsd_pkg::ST_CALC: lanes_en = 1'b1;
         tlsd_pkg::ST_WRITE: begin
            wr_en           = 1'b1;
            wr_bank         = !sel_ff;
            wr_addr         = x_ff;
            wr_data         = new_col;
            merge_ctrl.load = 1'b1;
         end
         tlsd_pkg::ST_FINISH: out_load = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_bank][wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[sel_ff][rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= tlsd_pkg::ST_IDLE;
         valid_ff[0]     <= '0;
         valid_ff[1]     <= '0;
         rd_valid_ff     <= 1'b0;
         sel_ff          <= 1'b0;
         fetch_ff        <= '0;
         x_ff            <= '0;
         last_hash_ff    <= '0;
         older_hash_ff   <= '0;
         repeat_count_ff <= '0;
         pending_ff      <= 1'b0;
         generation_ff   <= '0;
         repeat_limit_ff <= tlsd_pkg::LIMIT_DEFAULT;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write && (csr_paddr[2] == tlsd_pkg::CSR_REPEAT_LIMIT[2])) begin
            repeat_limit_ff <= csr_pwdata[7:0];
         end
         if (wr_en) begin
            valid_ff[wr_bank][wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[sel_ff][rd_addr];
         end
         if (state_ff == tlsd_pkg::ST_EXEC) begin
            if (action_ff == tlsd_pkg::ACT_CLEAR) begin
               valid_ff[0]     <= '0;
               valid_ff[1]     <= '0;
               last_hash_ff    <= '0;
               older_hash_ff   <= '0;
               repeat_count_ff <= '0;
               pending_ff      <= 1'b0;
            end else if (action_ff == tlsd_pkg::ACT_STEP) begin
               generation_ff <= generation_ff + 32'd1;
               fetch_ff      <= '0;
               x_ff          <= '0;
               if (pending_ff) begin
                  last_hash_ff    <= '0;
                  older_hash_ff   <= '0;
                  repeat_count_ff <= '0;
                  pending_ff      <= 1'b0;
               end
            end
         end
         if (state_ff == tlsd_pkg::ST_FETCH) begin
            fetch_ff <= fetch_ff + FW'(1);
         end
         if ((state_ff == tlsd_pkg::ST_HASH) && !merge_stat.busy) begin
            x_ff <= x_ff + CW'(1);
         end
         if (state_ff == tlsd_pkg::ST_EVAL) begin
            if ((merge_pop == '0) || (merge_hash == last_hash_ff)) begin
               pending_ff <= 1'b1;
            end else if (merge_hash == older_hash_ff) begin
               repeat_count_ff <= repeat_inc;
               if (repeat_inc >= repeat_limit_ff) pending_ff <= 1'b1;
            end else begin
               repeat_count_ff <= '0;
            end
            older_hash_ff <= last_hash_ff;
            last_hash_ff  <= merge_hash;
            sel_ff        <= !sel_ff;
         end
         if (out_load)        rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         action_ff <= tlsd_pkg::action_type'(req_tuser);
         column_ff <= req_tdata[5:0];
         cells_ff  <= req_tdata[37:6];
      end
      if (state_ff == tlsd_pkg::ST_LOAD) begin
         prev_ff <= cur_ff;
         cur_ff  <= nxt_ff;
         nxt_ff  <= rd_word;
      end
      if (out_load) begin
         out_cells_ff <= ((action_ff == tlsd_pkg::ACT_READ) && column_ok) ? rd_wide[31:0]
                                                                          : 32'd0;
         out_pop_ff   <= (action_ff == tlsd_pkg::ACT_STEP) ? pop_sat : 12'd0;
         out_hash_ff  <= (action_ff == tlsd_pkg::ACT_STEP) ? merge_hash : 32'd0;
         out_stim_ff  <= pending_ff;
         out_gen_ff   <= generation_ff;
      end
   end

   tlsd_lanes #(
      .GRID_HEIGHT(GRID_HEIGHT)
   ) u_lanes (
      .clock    (clock),
      .enable   (lanes_en),
      .prev_col (prev_ff),
      .cur_col  (cur_ff),
      .next_col (nxt_ff),
      .new_col  (new_col)
   );

   tlsd_merge #(
      .GRID_WIDTH (GRID_WIDTH),
      .GRID_HEIGHT(GRID_HEIGHT)
   ) u_merge (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (merge_ctrl),
      .column (new_col),
      .stat   (merge_stat),
      .hash   (merge_hash),
      .pop    (merge_pop)
   );

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == tlsd_pkg::CSR_REPEAT_LIMIT[2])
                       ? {24'd0, repeat_limit_ff} : 32'd0;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, out_gen_ff, out_stim_ff, out_hash_ff, out_pop_ff,
                        out_cells_ff};

   a_merge_in_hash : assert property (@(posedge clock) disable iff (reset)
      merge_stat.busy |-> (state_ff == tlsd_pkg::ST_HASH))
      else $error("merge stage busy outside the hash phase");

   a_bank_flip : assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlsd_pkg::ST_EVAL) |=> (sel_ff != $past(sel_ff)))
      else $error("grid bank did not swap after a step");

   a_fetch_bound : assert property (@(posedge clock) disable iff (reset)
      fetch_ff <= FW'(GRID_WIDTH + 2))
      else $error("column fetch count ran past the wrap column");

   a_step_only_pop : assert property (@(posedge clock) disable iff (reset)
      (out_load && (action_ff != tlsd_pkg::ACT_STEP)) |=> (out_pop_ff == 12'd0))
      else $error("population reported for a non-step transfer");

endmodule

[rtl/tlsd_lanes.sv]
// One Life rule lane per row, all rows of a column side by side.
// It depends on tlsd_pkg for its default height; the new column is registered.
module tlsd_lanes #(
   parameter int GRID_HEIGHT = tlsd_pkg::GRID_HEIGHT_DEF
) (
   input  logic                   clock,
   input  logic                   enable,
   input  logic [GRID_HEIGHT-1:0] prev_col,
   input  logic [GRID_HEIGHT-1:0] cur_col,
   input  logic [GRID_HEIGHT-1:0] next_col,
   output logic [GRID_HEIGHT-1:0] new_col
);

   logic [GRID_HEIGHT-1:0] col_in;
   logic [GRID_HEIGHT-1:0] col_ff;

   for (genvar y = 0; y < GRID_HEIGHT; y++) begin : g_lane
      localparam int UP = (y + 1) % GRID_HEIGHT;
      localparam int DN = (y + GRID_HEIGHT - 1) % GRID_HEIGHT;
      logic [3:0] count;
      assign count = 4'(prev_col[DN]) + 4'(prev_col[y]) + 4'(prev_col[UP])
                   + 4'(cur_col[DN]) + 4'(cur_col[UP])
                   + 4'(next_col[DN]) + 4'(next_col[y]) + 4'(next_col[UP]);
      assign col_in[y] = (count == 4'd3) || (cur_col[y] && (count == 4'd2));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         col_ff <= col_in;
      end
   end

   assign new_col = col_ff;

endmodule

[rtl/tlsd_merge.sv]
// Merging stage: folds the lanes' column into the FNV-1a hash and the
// live count, one cell per cycle. It depends on tlsd_pkg.
module tlsd_merge #(
   parameter int GRID_WIDTH  = tlsd_pkg::GRID_WIDTH_DEF,
   parameter int GRID_HEIGHT = tlsd_pkg::GRID_HEIGHT_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  tlsd_pkg::merge_ctrl_type                  ctrl,
   input  logic [GRID_HEIGHT-1:0]                    column,
   output tlsd_pkg::merge_stat_type                  stat,
   output logic [31:0]                               hash,
   output logic [$clog2(GRID_WIDTH*GRID_HEIGHT+1)-1:0] pop
);

   localparam int PW = $clog2(GRID_WIDTH * GRID_HEIGHT + 1);
   localparam int NW = $clog2(GRID_HEIGHT + 1);

   logic [NW-1:0]          cnt_ff;
   logic [GRID_HEIGHT-1:0] shift_ff;
   logic [31:0]            hash_ff;
   logic [31:0]            hash_in;
   logic [PW-1:0]          pop_ff;

   assign hash_in = (hash_ff ^ 32'(shift_ff[0])) * tlsd_pkg::FNV_PRIME;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (ctrl.load) begin
         cnt_ff <= NW'(GRID_HEIGHT);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.init) begin
         hash_ff <= tlsd_pkg::FNV_BASIS;
         pop_ff  <= '0;
      end else if (ctrl.load) begin
         shift_ff <= column;
      end else if (cnt_ff != '0) begin
         hash_ff  <= hash_in;
         pop_ff   <= pop_ff + PW'(shift_ff[0]);
         shift_ff <= shift_ff >> 1;
      end
   end

   assign stat.busy = (cnt_ff != '0);
   assign hash      = hash_ff;
   assign pop       = pop_ff;

endmodule
